// ===== hdl/cau_pkg.sv =====
// Package for the complex arithmetic unit: operation codes and width defaults.
// Used by complex_arithmetic_unit; depends on nothing else.
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;

    typedef enum logic [2:0] {
        OP_EQ  = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4
    } op_t;

endpackage

// ===== hdl/complex_arithmetic_unit.sv =====
// Complex-number ALU on signed fixed-point operands, pipelined with a
// restoring divider unrolled into stages. Depends on cau_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | s_valid / s_ready    | s_op, s_a_re, s_a_im, s_b_re, s_b_im
//  result   | m_valid / m_ready    | m_res_re, m_res_im, m_is_equal,
//           |                      | m_div_by_zero, m_saturated
//
// One item enters per cycle while the result register is empty or being taken. Stages:
// product stage, sum stage, sign/magnitude stage, DATA_WIDTH + 1 quotient bit
// stages of the divider, and the saturating output register.
// Reset (aresetn low, synchronous) clears all valid bits.
// When the output item is not taken the whole pipeline holds; nothing is lost.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_op,
    input  logic signed [DATA_WIDTH-1:0] s_a_re,
    input  logic signed [DATA_WIDTH-1:0] s_a_im,
    input  logic signed [DATA_WIDTH-1:0] s_b_re,
    input  logic signed [DATA_WIDTH-1:0] s_b_im,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_res_re,
    output logic signed [DATA_WIDTH-1:0] m_res_im,
    output logic                         m_is_equal,
    output logic                         m_div_by_zero,
    output logic                         m_saturated
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = DATA_WIDTH / 2;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int MW = PW;
    localparam int QW = DATA_WIDTH + 1;
    localparam int NW = MW + F;
    localparam logic [MW-1:0] HALF_M = MW'(1) << (W - 1);

    function automatic logic [W:0] clamp_fn(input logic neg, input logic [MW-1:0] mag);
        logic [W:0] r;
        if (!neg) begin
            if (mag > HALF_M - MW'(1)) r = {1'b1, W'(HALF_M - MW'(1))};
            else                       r = {1'b0, mag[W-1:0]};
        end else begin
            if (mag > HALF_M) r = {1'b1, W'(MW'(0) - HALF_M)};
            else              r = {1'b0, W'(MW'(0) - mag)};
        end
        return r;
    endfunction

    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // stage 1: products, short sums, equality, zero-divisor flag
    logic               s1_valid_reg;
    logic [2:0]         s1_op_reg;
    logic signed [PW-1:0] s1_ac_reg, s1_bd_reg, s1_ad_reg, s1_bc_reg, s1_cc_reg, s1_dd_reg;
    logic signed [W:0]  s1_sre_reg, s1_sim_reg;
    logic               s1_eq_reg, s1_dz_reg;
    logic signed [W:0]  sre_next, sim_next;

    always_comb begin
        if (s_op == cau_pkg::OP_SUB) begin
            sre_next = (W+1)'(s_a_re) - (W+1)'(s_b_re);
            sim_next = (W+1)'(s_a_im) - (W+1)'(s_b_im);
        end else begin
            sre_next = (W+1)'(s_a_re) + (W+1)'(s_b_re);
            sim_next = (W+1)'(s_a_im) + (W+1)'(s_b_im);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
        end
        if (adv) begin
            s1_op_reg  <= s_op;
            s1_ac_reg  <= PW'(s_a_re) * PW'(s_b_re);
            s1_bd_reg  <= PW'(s_a_im) * PW'(s_b_im);
            s1_ad_reg  <= PW'(s_a_re) * PW'(s_b_im);
            s1_bc_reg  <= PW'(s_a_im) * PW'(s_b_re);
            s1_cc_reg  <= PW'(s_b_re) * PW'(s_b_re);
            s1_dd_reg  <= PW'(s_b_im) * PW'(s_b_im);
            s1_sre_reg <= sre_next;
            s1_sim_reg <= sim_next;
            s1_eq_reg  <= (s_a_re == s_b_re) && (s_a_im == s_b_im);
            s1_dz_reg  <= (s_b_re == '0) && (s_b_im == '0);
        end
    end

    // stage 2: wide sums
    logic                s2_valid_reg;
    logic [2:0]          s2_op_reg;
    logic signed [PW:0]  s2_xre_reg, s2_xim_reg;
    logic [MW-1:0]       s2_den_reg;
    logic signed [W:0]   s2_sre_reg, s2_sim_reg;
    logic                s2_eq_reg, s2_dz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (adv) begin
            s2_op_reg <= s1_op_reg;
            if (s1_op_reg == cau_pkg::OP_DIV) begin
                s2_xre_reg <= (PW+1)'(s1_ac_reg) + (PW+1)'(s1_bd_reg);
                s2_xim_reg <= (PW+1)'(s1_bc_reg) - (PW+1)'(s1_ad_reg);
            end else begin
                s2_xre_reg <= (PW+1)'(s1_ac_reg) - (PW+1)'(s1_bd_reg);
                s2_xim_reg <= (PW+1)'(s1_ad_reg) + (PW+1)'(s1_bc_reg);
            end
            s2_den_reg <= MW'(s1_cc_reg) + MW'(s1_dd_reg);
            s2_sre_reg <= s1_sre_reg;
            s2_sim_reg <= s1_sim_reg;
            s2_eq_reg  <= s1_eq_reg;
            s2_dz_reg  <= s1_dz_reg;
        end
    end

    // stage 3: sign/magnitude, finished results for all but divide, divider setup
    logic [PW:0]   xre_abs, xim_abs;
    logic [W:0]    sre_abs, sim_abs;
    logic          nre_next, nim_next;
    logic [MW-1:0] mre_next, mim_next;
    logic [NW-1:0] nre_div, nim_div;
    logic [W:0]    cre, cim;
    logic [W-1:0]  res_re_next, res_im_next;
    logic          sat_next, eq_next;

    always_comb begin
        xre_abs  = s2_xre_reg[PW] ? (~s2_xre_reg + 1'b1) : s2_xre_reg;
        xim_abs  = s2_xim_reg[PW] ? (~s2_xim_reg + 1'b1) : s2_xim_reg;
        sre_abs  = s2_sre_reg[W] ? (~s2_sre_reg + 1'b1) : s2_sre_reg;
        sim_abs  = s2_sim_reg[W] ? (~s2_sim_reg + 1'b1) : s2_sim_reg;
        mre_next = xre_abs[MW-1:0];
        mim_next = xim_abs[MW-1:0];
        nre_next = s2_xre_reg[PW];
        nim_next = s2_xim_reg[PW];
        nre_div  = {mre_next, F'(0)};
        nim_div  = {mim_next, F'(0)};
        cre = '0;
        cim = '0;
        eq_next = 1'b0;
        if (s2_op_reg == cau_pkg::OP_ADD || s2_op_reg == cau_pkg::OP_SUB) begin
            cre = clamp_fn(s2_sre_reg[W], MW'(sre_abs));
            cim = clamp_fn(s2_sim_reg[W], MW'(sim_abs));
        end else if (s2_op_reg == cau_pkg::OP_MUL) begin
            cre = clamp_fn(nre_next, mre_next >> F);
            cim = clamp_fn(nim_next, mim_next >> F);
        end else if (s2_op_reg == cau_pkg::OP_EQ) begin
            eq_next = s2_eq_reg;
        end
        res_re_next = cre[W-1:0];
        res_im_next = cim[W-1:0];
        sat_next    = cre[W] | cim[W];
    end

    // divider stages: index k holds the item after k quotient bits
    logic          d_valid_reg [QW+1];
    logic [2:0]    d_op_reg    [QW+1];
    logic          d_nre_reg   [QW+1];
    logic          d_nim_reg   [QW+1];
    logic          d_ovr_reg   [QW+1];
    logic          d_ovi_reg   [QW+1];
    logic          d_dz_reg    [QW+1];
    logic          d_eq_reg    [QW+1];
    logic          d_sat_reg   [QW+1];
    logic [W-1:0]  d_rre_reg   [QW+1];
    logic [W-1:0]  d_rim_reg   [QW+1];
    logic [MW-1:0] d_den_reg   [QW+1];
    logic [MW-1:0] d_remr_reg  [QW+1];
    logic [MW-1:0] d_remi_reg  [QW+1];
    logic [QW-1:0] d_lowr_reg  [QW+1];
    logic [QW-1:0] d_lowi_reg  [QW+1];
    logic [QW-1:0] d_qr_reg    [QW+1];
    logic [QW-1:0] d_qi_reg    [QW+1];

    logic [MW:0]   remr2 [QW];
    logic [MW:0]   remi2 [QW];
    logic          bitr  [QW];
    logic          biti  [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            remr2[k] = {d_remr_reg[k], d_lowr_reg[k][QW-1]};
            remi2[k] = {d_remi_reg[k], d_lowi_reg[k][QW-1]};
            bitr[k]  = remr2[k] >= {1'b0, d_den_reg[k]};
            biti[k]  = remi2[k] >= {1'b0, d_den_reg[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QW; k++) d_valid_reg[k] <= 1'b0;
        end else if (adv) begin
            d_valid_reg[0] <= s2_valid_reg;
            for (int k = 0; k < QW; k++) d_valid_reg[k+1] <= d_valid_reg[k];
        end
        if (adv) begin
            d_op_reg[0]   <= s2_op_reg;
            d_nre_reg[0]  <= nre_next;
            d_nim_reg[0]  <= nim_next;
            d_ovr_reg[0]  <= (nre_div >> QW) >= NW'(s2_den_reg);
            d_ovi_reg[0]  <= (nim_div >> QW) >= NW'(s2_den_reg);
            d_dz_reg[0]   <= s2_dz_reg && (s2_op_reg == cau_pkg::OP_DIV);
            d_eq_reg[0]   <= eq_next;
            d_sat_reg[0]  <= sat_next;
            d_rre_reg[0]  <= res_re_next;
            d_rim_reg[0]  <= res_im_next;
            d_den_reg[0]  <= s2_den_reg;
            d_remr_reg[0] <= MW'(nre_div >> QW);
            d_remi_reg[0] <= MW'(nim_div >> QW);
            d_lowr_reg[0] <= nre_div[QW-1:0];
            d_lowi_reg[0] <= nim_div[QW-1:0];
            d_qr_reg[0]   <= '0;
            d_qi_reg[0]   <= '0;
            for (int k = 0; k < QW; k++) begin
                d_op_reg[k+1]   <= d_op_reg[k];
                d_nre_reg[k+1]  <= d_nre_reg[k];
                d_nim_reg[k+1]  <= d_nim_reg[k];
                d_ovr_reg[k+1]  <= d_ovr_reg[k];
                d_ovi_reg[k+1]  <= d_ovi_reg[k];
                d_dz_reg[k+1]   <= d_dz_reg[k];
                d_eq_reg[k+1]   <= d_eq_reg[k];
                d_sat_reg[k+1]  <= d_sat_reg[k];
                d_rre_reg[k+1]  <= d_rre_reg[k];
                d_rim_reg[k+1]  <= d_rim_reg[k];
                d_den_reg[k+1]  <= d_den_reg[k];
                d_remr_reg[k+1] <= bitr[k] ? MW'(remr2[k] - {1'b0, d_den_reg[k]})
                                           : MW'(remr2[k]);
                d_remi_reg[k+1] <= biti[k] ? MW'(remi2[k] - {1'b0, d_den_reg[k]})
                                           : MW'(remi2[k]);
                d_lowr_reg[k+1] <= d_lowr_reg[k] << 1;
                d_lowi_reg[k+1] <= d_lowi_reg[k] << 1;
                d_qr_reg[k+1]   <= {d_qr_reg[k][QW-2:0], bitr[k]};
                d_qi_reg[k+1]   <= {d_qi_reg[k][QW-2:0], biti[k]};
            end
        end
    end

    // output register: saturate the quotient for divide (zero on a zero divisor), else pass through
    logic [MW-1:0] qmr, qmi;
    logic [W:0]    qcr, qci;
    logic [W-1:0]  out_re_next, out_im_next;
    logic          out_sat_next;

    always_comb begin
        qmr = d_ovr_reg[QW] ? {MW{1'b1}} : MW'(d_qr_reg[QW]);
        qmi = d_ovi_reg[QW] ? {MW{1'b1}} : MW'(d_qi_reg[QW]);
        qcr = clamp_fn(d_nre_reg[QW], qmr);
        qci = clamp_fn(d_nim_reg[QW], qmi);
        if (d_op_reg[QW] == cau_pkg::OP_DIV) begin
            if (d_dz_reg[QW]) begin
                out_re_next  = '0;
                out_im_next  = '0;
                out_sat_next = 1'b0;
            end else begin
                out_re_next  = qcr[W-1:0];
                out_im_next  = qci[W-1:0];
                out_sat_next = qcr[W] | qci[W];
            end
        end else begin
            out_re_next  = d_rre_reg[QW];
            out_im_next  = d_rim_reg[QW];
            out_sat_next = d_sat_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= d_valid_reg[QW];
        end
        if (adv) begin
            m_res_re      <= out_re_next;
            m_res_im      <= out_im_next;
            m_is_equal    <= d_eq_reg[QW];
            m_div_by_zero <= d_dz_reg[QW];
            m_saturated   <= out_sat_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== tb/sv/tb_complex_arithmetic_unit.sv =====
// Self-checking testbench for complex_arithmetic_unit: directed table, then random items,
// each result compared with an in-bench fixed-point predictor. Depends on cau_pkg.
module tb_complex_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 16;
    localparam int FB = W / 2;
    localparam int LATENCY = W + 5;
    localparam int LIMIT = 400000;
    localparam logic signed [W-1:0] MAXV = 16'sh7fff;
    localparam logic signed [W-1:0] MINV = 16'sh8000;

    typedef struct packed {
        logic [2:0] op;
        logic signed [W-1:0] a_re, a_im, b_re, b_im;
    } cmd_t;

    typedef struct packed {
        logic signed [W-1:0] re, im;
        logic eq, dz, sat;
    } res_t;

    typedef struct {
        cmd_t cmd;
        bit   known;
        res_t res;
    } row_t;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, m_valid, m_ready = 0;
    logic [2:0] s_op = '0;
    logic signed [W-1:0] s_a_re = '0, s_a_im = '0, s_b_re = '0, s_b_im = '0;
    logic signed [W-1:0] m_res_re, m_res_im;
    logic m_is_equal, m_div_by_zero, m_saturated;

    complex_arithmetic_unit #(.DATA_WIDTH(W)) dut (.*);

    always #10 aclk = ~aclk;

    res_t pending_results[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   send_idle = 0, recv_stall = 0;

    // Clamp a wide value to the signed output range.
    function automatic logic signed [W-1:0] clip(input logic signed [63:0] v, inout logic sat);
        if (v > 64'sd32767) begin sat = 1; return MAXV; end
        if (v < -64'sd32768) begin sat = 1; return MINV; end
        return v[W-1:0];
    endfunction

    // Truncating fixed-point quotient, limited to 65536, beyond the output range.
    function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                  input logic signed [63:0] d);
        logic [63:0] mag, q;
        mag = (n < 0) ? -n : n;
        q = (mag << FB) / d;
        if (q > 64'd65536) q = 64'd65536;
        return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic res_t cau_predict(input cmd_t c);
        res_t r;
        logic signed [63:0] a, b, x, y, nr, ni, den;
        r = '0;
        a = c.a_re; b = c.a_im; x = c.b_re; y = c.b_im;
        case (c.op)
            cau_pkg::OP_EQ: r.eq = (a == x) && (b == y);
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                nr = (c.op == cau_pkg::OP_ADD) ? a + x : a - x;
                ni = (c.op == cau_pkg::OP_ADD) ? b + y : b - y;
                r.re = clip(nr, r.sat);
                r.im = clip(ni, r.sat);
            end
            cau_pkg::OP_MUL: begin
                nr = a * x - b * y;
                ni = a * y + b * x;
                // truncate toward zero
                nr = (nr < 0) ? -((-nr) >>> FB) : nr >>> FB;
                ni = (ni < 0) ? -((-ni) >>> FB) : ni >>> FB;
                r.re = clip(nr, r.sat);
                r.im = clip(ni, r.sat);
            end
            cau_pkg::OP_DIV: begin
                if (x == 0 && y == 0) begin
                    r.dz = 1;
                end else begin
                    den = x * x + y * y;
                    r.re = clip(fx_div(a * x + b * y, den), r.sat);
                    r.im = clip(fx_div(b * x - a * y, den), r.sat);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic res_t mk(input logic signed [W-1:0] re, im, input logic eq, dz, sat);
        res_t r;
        r.re = re; r.im = im; r.eq = eq; r.dz = dz; r.sat = sat;
        return r;
    endfunction

    function automatic logic signed [W-1:0] rand_val();
        case ($urandom_range(0, 5))
            0: return MAXV;
            1: return MINV;
            2: return W'($urandom_range(0, 3) - 1);
            3: return W'($signed(16'($urandom_range(0, 1023))) - 512);
            default: return W'($urandom);
        endcase
    endfunction

    // Enter and leave at a falling edge; valid stays high between back-to-back items.
    task automatic send(input cmd_t c);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_op <= c.op; s_a_re <= c.a_re; s_a_im <= c.a_im;
        s_b_re <= c.b_re; s_b_im <= c.b_im;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(cau_predict(c));
        @(negedge aclk);
    endtask

    always @(negedge aclk) m_ready <= ($urandom_range(0, 99) >= recv_stall);

    always @(posedge aclk) begin
        res_t got, want;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            got = mk(m_res_re, m_res_im, m_is_equal, m_div_by_zero, m_saturated);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    row_t directed[$];

    task automatic add_row(input logic [2:0] op, input logic signed [W-1:0] ar, ai, br, bi,
                           input bit known, input res_t r);
        row_t row;
        row.cmd = {op, ar, ai, br, bi};
        row.known = known;
        row.res = r;
        directed.push_back(row);
    endtask

    initial begin
        cmd_t c;
        res_t z;
        z = '0;
        add_row(cau_pkg::OP_EQ, 16'sd5, -16'sd3, 16'sd5, -16'sd3, 1, mk(0, 0, 1, 0, 0));
        add_row(cau_pkg::OP_EQ, 16'sd5, -16'sd3, 16'sd5, 16'sd3, 1, z);
        add_row(cau_pkg::OP_EQ, MINV, MAXV, MINV, MAXV, 1, mk(0, 0, 1, 0, 0));
        add_row(cau_pkg::OP_ADD, MAXV, MINV, MAXV, MINV, 1, mk(MAXV, MINV, 0, 0, 1));
        add_row(cau_pkg::OP_ADD, 16'sd256, -16'sd256, 16'sd1, 16'sd1, 1,
                mk(257, -255, 0, 0, 0));
        add_row(cau_pkg::OP_SUB, MINV, MAXV, MAXV, MINV, 1, mk(MINV, MAXV, 0, 0, 1));
        add_row(cau_pkg::OP_SUB, MAXV, MAXV, MAXV, MAXV, 1, z);
        add_row(cau_pkg::OP_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1, mk(256, 0, 0, 0, 0));
        add_row(cau_pkg::OP_MUL, MINV, MINV, MINV, MINV, 0, z);
        add_row(cau_pkg::OP_MUL, MAXV, MINV, MAXV, MAXV, 0, z);
        add_row(cau_pkg::OP_MUL, -16'sd1, 16'sd1, 16'sd1, 16'sd1, 0, z);
        add_row(cau_pkg::OP_DIV, 16'sd100, 16'sd7, 16'sd0, 16'sd0, 1, mk(0, 0, 0, 1, 0));
        add_row(cau_pkg::OP_DIV, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1, mk(256, 0, 0, 0, 0));
        add_row(cau_pkg::OP_DIV, MAXV, MAXV, 16'sd1, 16'sd0, 1, mk(MAXV, MAXV, 0, 0, 1));
        add_row(cau_pkg::OP_DIV, MINV, MINV, 16'sd0, 16'sd1, 0, z);
        add_row(cau_pkg::OP_DIV, MINV, MAXV, MINV, MINV, 0, z);
        add_row(cau_pkg::OP_DIV, -16'sd1, 16'sd0, MAXV, MAXV, 0, z);
        add_row(3'd5, MAXV, MAXV, MAXV, MAXV, 1, z);
        add_row(3'd6, MINV, MINV, 16'sd0, 16'sd0, 1, z);
        add_row(3'd7, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1, z);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        foreach (directed[i]) begin
            if (directed[i].known && cau_predict(directed[i].cmd) !== directed[i].res) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: expected %p predicted %p", i, directed[i].res,
                             cau_predict(directed[i].cmd));
            end
            send(directed[i].cmd);
        end

        // Walk the idling phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1) ? 80 : (ph == 3) ? 36 : 0;
            recv_stall = (ph == 2) ? 80 : (ph == 3) ? 36 : 0;
            for (int n = 0; n < 100; n++) begin
                c.op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
                c.a_re = rand_val(); c.a_im = rand_val();
                c.b_re = rand_val(); c.b_im = rand_val();
                if (c.op == cau_pkg::OP_EQ && $urandom_range(0, 1)) begin
                    c.b_re = c.a_re; c.b_im = c.a_im;
                end
                if (c.op == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
                    c.b_re = '0; c.b_im = '0;
                end
                send(c);
            end
        end
        s_valid <= 0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
